[rtl/core/cbe_pkg.sv]
`default_nettype none
package cbe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLE1_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLE1_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLE2_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLE2_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FINISH_X   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FINISH_Y   = 3'd7;

    // back pipeline layout
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 33;
    localparam int ST_SQRT0   = 1;
    localparam int ST_PP      = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_DEN     = ST_PP + 1;
    localparam int ST_DIV0    = ST_DEN + 1;
    localparam int NB         = ST_DIV0 + DIV_STEPS;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [26:0] vx;
        logic signed [26:0] vy;
        logic signed [28:0] ax;
        logic signed [28:0] ay;
        logic               neg;
        logic               zero;
        logic [53:0]        n;
        logic [63:0]        rem;
        logic [63:0]        root;
        logic [42:0]        pp0;
        logic [43:0]        pp1;
        logic [42:0]        pp2;
        logic [43:0]        pp3;
        logic [87:0]        den;
        logic [92:0]        num;
        logic [32:0]        q;
    } t_stage;

    // a + round((b-a)*t / 2^FRAC_BITS), halves up
    function automatic logic signed [23:0] lerp(input logic signed [23:0] a,
                                                input logic signed [23:0] b,
                                                input logic [16:0] t);
        logic signed [24:0] d;
        logic signed [42:0] p;
        logic signed [42:0] s;
        d = 25'(b) - 25'(a);
        p = 43'(d) * 43'($signed({1'b0, t}));
        s = p + (43'sd1 <<< (FRAC_BITS - 1));
        s = s >>> FRAC_BITS;
        return a + s[23:0];
    endfunction

endpackage
`default_nettype wire

[rtl/core/cubic_bezier_evaluator.sv]
// Cubic Bezier evaluator: point, velocity, acceleration and curvature per t.
// Pipeline: 73 register stages (4 curve, setup, 32 sqrt, 2 multiply, 33 divide and
// the output register).
// Throughput: one item per cycle; the whole pipeline holds while the output
// is stalled. Reset (synchronous, active low) clears all valid bits and sets
// the control point registers to zero.
`default_nettype none
module cubic_bezier_evaluator import cbe_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [23:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_ready,
    input  wire logic [16:0]          i_param_t,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    output      logic signed [23:0]   o_point_x,
    output      logic signed [23:0]   o_point_y,
    output      logic signed [26:0]   o_velocity_x,
    output      logic signed [26:0]   o_velocity_y,
    output      logic signed [28:0]   o_accel_x,
    output      logic signed [28:0]   o_accel_y,
    output      logic signed [31:0]   o_curvature
);

    logic signed [23:0] r_cp_x [4];
    logic signed [23:0] r_cp_y [4];

    logic en;
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_cp_x[i] <= '0;
                r_cp_y[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_X:   r_cp_x[0] <= i_cfg_data;
                REG_START_Y:   r_cp_y[0] <= i_cfg_data;
                REG_HANDLE1_X: r_cp_x[1] <= i_cfg_data;
                REG_HANDLE1_Y: r_cp_y[1] <= i_cfg_data;
                REG_HANDLE2_X: r_cp_x[2] <= i_cfg_data;
                REG_HANDLE2_Y: r_cp_y[2] <= i_cfg_data;
                REG_FINISH_X:  r_cp_x[3] <= i_cfg_data;
                REG_FINISH_Y:  r_cp_y[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- curve stages ----------------
    logic [3:0] r_fv;
    logic [16:0] r_t1, r_t2;
    logic signed [23:0] r_r1x [3], r_r1y [3];
    logic signed [23:0] r_r2x [3], r_r2y [3];
    logic signed [23:0] r_q2x [2], r_q2y [2];
    logic signed [23:0] r_px3, r_py3, r_px4, r_py4;
    logic signed [26:0] r_vx3, r_vy3, r_vx4, r_vy4;
    logic signed [28:0] r_ax3, r_ay3, r_ax4, r_ay4;
    logic signed [55:0] r_vxay, r_vyax;
    logic signed [53:0] r_vxvx, r_vyvy;

    logic [16:0] n_t;
    assign n_t = (i_param_t > 17'(1 << FRAC_BITS)) ? 17'(1 << FRAC_BITS) : i_param_t;

    logic signed [24:0] dx3, dy3;
    logic signed [26:0] sx3, sy3;
    always_comb begin
        dx3 = 25'(r_q2x[1]) - 25'(r_q2x[0]);
        dy3 = 25'(r_q2y[1]) - 25'(r_q2y[0]);
        sx3 = 27'(r_r2x[2]) - (27'(r_r2x[1]) <<< 1) + 27'(r_r2x[0]);
        sy3 = 27'(r_r2y[2]) - (27'(r_r2y[1]) <<< 1) + 27'(r_r2y[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (en) begin
            r_fv <= {r_fv[2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1 <= n_t;
            for (int i = 0; i < 3; i++) begin
                r_r1x[i] <= lerp(r_cp_x[i], r_cp_x[i+1], n_t);
                r_r1y[i] <= lerp(r_cp_y[i], r_cp_y[i+1], n_t);
            end
            r_t2 <= r_t1;
            for (int i = 0; i < 3; i++) begin
                r_r2x[i] <= r_r1x[i];
                r_r2y[i] <= r_r1y[i];
            end
            for (int i = 0; i < 2; i++) begin
                r_q2x[i] <= lerp(r_r1x[i], r_r1x[i+1], r_t1);
                r_q2y[i] <= lerp(r_r1y[i], r_r1y[i+1], r_t1);
            end
            r_px3 <= lerp(r_q2x[0], r_q2x[1], r_t2);
            r_py3 <= lerp(r_q2y[0], r_q2y[1], r_t2);
            r_vx3 <= (27'(dx3) <<< 1) + 27'(dx3);
            r_vy3 <= (27'(dy3) <<< 1) + 27'(dy3);
            r_ax3 <= (29'(sx3) <<< 2) + (29'(sx3) <<< 1);
            r_ay3 <= (29'(sy3) <<< 2) + (29'(sy3) <<< 1);
            r_px4 <= r_px3;
            r_py4 <= r_py3;
            r_vx4 <= r_vx3;
            r_vy4 <= r_vy3;
            r_ax4 <= r_ax3;
            r_ay4 <= r_ay3;
            r_vxay <= 56'(r_vx3) * 56'(r_ay3);
            r_vyax <= 56'(r_vy3) * 56'(r_ax3);
            r_vxvx <= 54'(r_vx3) * 54'(r_vx3);
            r_vyvy <= 54'(r_vy3) * 54'(r_vy3);
        end
    end

    // ---------------- curvature stages ----------------
    t_stage r_st [NB];
    t_stage n_st [NB];
    logic [NB-1:0] r_bv;

    logic signed [56:0] vcross;
    logic [55:0] mag;
    logic [53:0] nsum;
    always_comb begin
        vcross = 57'(r_vxay) - 57'(r_vyax);
        mag    = vcross[56] ? 56'(-vcross) : vcross[55:0];
        nsum   = r_vxvx[53:0] + r_vyvy[53:0];
    end

    always_comb begin
        logic [63:0]  bitv;
        logic [63:0]  trial;
        logic [120:0] d;
        for (int i = 0; i < NB; i++) begin
            bitv  = '0;
            trial = '0;
            d     = '0;
            if (i == 0) begin
                n_st[i]      = '0;
                n_st[i].px   = r_px4;
                n_st[i].py   = r_py4;
                n_st[i].vx   = r_vx4;
                n_st[i].vy   = r_vy4;
                n_st[i].ax   = r_ax4;
                n_st[i].ay   = r_ay4;
                n_st[i].neg  = vcross[56];
                n_st[i].zero = (nsum == '0) || (vcross == '0);
                n_st[i].n    = nsum;
                n_st[i].rem  = {nsum, 10'b0};
                n_st[i].root = '0;
                n_st[i].num  = {mag, 37'b0};
            end else begin
                n_st[i] = r_st[i-1];
                if (i < ST_PP) begin
                    bitv  = 64'd1 << (62 - 2 * (i - ST_SQRT0));
                    trial = r_st[i-1].root + bitv;
                    if (r_st[i-1].rem >= trial) begin
                        n_st[i].rem  = r_st[i-1].rem - trial;
                        n_st[i].root = (r_st[i-1].root >> 1) + bitv;
                    end else begin
                        n_st[i].root = r_st[i-1].root >> 1;
                    end
                end else if (i == ST_PP) begin
                    n_st[i].pp0 = 43'(r_st[i-1].n[26:0])  * 43'(r_st[i-1].root[15:0]);
                    n_st[i].pp1 = 44'(r_st[i-1].n[26:0])  * 44'(r_st[i-1].root[32:16]);
                    n_st[i].pp2 = 43'(r_st[i-1].n[53:27]) * 43'(r_st[i-1].root[15:0]);
                    n_st[i].pp3 = 44'(r_st[i-1].n[53:27]) * 44'(r_st[i-1].root[32:16]);
                end else if (i == ST_DEN) begin
                    n_st[i].den = 88'(r_st[i-1].pp0)
                                + (88'(r_st[i-1].pp1) << 16)
                                + (88'(r_st[i-1].pp2) << 27)
                                + (88'(r_st[i-1].pp3) << 43);
                end else begin
                    // restoring divide, quotient bit 32 down to 0
                    d = 121'(r_st[i-1].den) << (DIV_STEPS - 1 - (i - ST_DIV0));
                    if (121'(r_st[i-1].num) >= d) begin
                        n_st[i].num = r_st[i-1].num - d[92:0];
                        n_st[i].q[DIV_STEPS - 1 - (i - ST_DIV0)] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (en) begin
            r_bv <= {r_bv[NB-2:0], r_fv[3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NB; i++) r_st[i] <= n_st[i];
        end
    end

    // ---------------- output register ----------------
    t_stage fin;
    logic signed [31:0] n_k;
    assign fin = r_st[NB-1];
    always_comb begin
        if (fin.zero) begin
            n_k = '0;
        end else if (!fin.neg) begin
            n_k = (fin.q > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : 32'(fin.q);
        end else begin
            n_k = (fin.q > 33'h080000000) ? 32'sh80000000 : 32'(-fin.q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r_bv[NB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_point_x    <= fin.px;
            o_point_y    <= fin.py;
            o_velocity_x <= fin.vx;
            o_velocity_y <= fin.vy;
            o_accel_x    <= fin.ax;
            o_accel_y    <= fin.ay;
            o_curvature  <= n_k;
        end
    end

endmodule
`default_nettype wire

[tb/sv/tb_cubic_bezier_evaluator.sv]
`timescale 1ns / 1ps
module tb_cubic_bezier_evaluator;
    import cbe_pkg::*;

    localparam int  N_RANDOM    = 1100;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  DRAIN_WAIT  = 90;
    localparam logic signed [23:0] CP_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] CP_MIN = 24'sh800000;

    // control point presets used by the directed table
    typedef enum int {
        PRE_RESET, PRE_ALL_MAX, PRE_ZIGZAG, PRE_SCURVE, PRE_KINK_POS, PRE_KINK_NEG
    } t_preset;

    typedef struct {
        logic signed [23:0] px, py;
        logic signed [26:0] vx, vy;
        logic signed [28:0] ax, ay;
        logic signed [31:0] k;
    } t_curve_sample;

    typedef struct {
        logic [16:0] t;
        t_preset     pre;
        bit          typed;     // expected point given inline, rest zero
        logic signed [23:0] pt;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [23:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [16:0]          i_param_t = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [23:0]   o_point_x, o_point_y;
    logic signed [26:0]   o_velocity_x, o_velocity_y;
    logic signed [28:0]   o_accel_x, o_accel_y;
    logic signed [31:0]   o_curvature;

    cubic_bezier_evaluator dut (.*);

    always #5 i_clk = ~i_clk;

    logic signed [23:0] ctrl_pts [NUM_REGS];
    t_curve_sample      pending_samples [$];
    int                 fail_cnt = 0;
    int                 cycle_cnt = 0;
    bit                 quiet = 1'b0;
    bit                 long_hold_req = 1'b0;

    function automatic longint bz_lerp(longint a, longint b, longint t);
        return a + (((b - a) * t + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= r + bit_v) begin
                n = n - (r + bit_v);
                r = (r >> 1) + bit_v;
            end else begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    function automatic longint signed_curvature(longint vx, longint vy, longint ax, longint ay);
        longint          vcross;
        longint unsigned n, mag, m;
        logic [127:0]    num, den, q;
        vcross = vx * ay - vy * ax;
        n = longint'(vx * vx) + longint'(vy * vy);
        if (n == 0 || vcross == 0) return 0;
        mag = vcross < 0 ? -vcross : vcross;
        m = int_sqrt(n << 10);
        num = {64'd0, mag} << (2 * FRAC_BITS + 5);
        den = {64'd0, n} * {64'd0, m};
        q = num / den;
        if (vcross > 0) return q > 128'd2147483647 ? 64'sd2147483647 : longint'(q);
        return q > 128'd2147483648 ? -64'sd2147483648 : -longint'(q);
    endfunction

    task automatic eval_axis(input longint p0, p1, p2, p3, t,
                             output longint pt, vel, acc);
        longint r0, r1, r2, q0, q1;
        r0 = bz_lerp(p0, p1, t);
        r1 = bz_lerp(p1, p2, t);
        r2 = bz_lerp(p2, p3, t);
        q0 = bz_lerp(r0, r1, t);
        q1 = bz_lerp(r1, r2, t);
        pt = bz_lerp(q0, q1, t);
        vel = 3 * (q1 - q0);
        acc = 6 * (r2 - 2 * r1 + r0);
    endtask

    task automatic predict_sample(input logic [16:0] t_in, output t_curve_sample s);
        longint t, ptx, pty, vx, vy, ax, ay;
        t = t_in > 17'd65536 ? 65536 : t_in;
        eval_axis(ctrl_pts[0], ctrl_pts[2], ctrl_pts[4], ctrl_pts[6], t, ptx, vx, ax);
        eval_axis(ctrl_pts[1], ctrl_pts[3], ctrl_pts[5], ctrl_pts[7], t, pty, vy, ay);
        s.px = ptx[23:0];
        s.py = pty[23:0];
        s.vx = vx[26:0];
        s.vy = vy[26:0];
        s.ax = ax[28:0];
        s.ay = ay[28:0];
        s.k  = 32'(signed_curvature(vx, vy, ax, ay));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ctrl_pts[idx] = val;
    endtask

    // drop valid after the last transfer, then let the pipeline drain
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic load_points(input logic signed [23:0] v [NUM_REGS]);
        wait_idle();
        for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), v[i]);
    endtask

    task automatic load_preset(input t_preset p);
        logic signed [23:0] v [NUM_REGS];
        case (p)
            PRE_ALL_MAX: v = '{CP_MAX, CP_MAX, CP_MAX, CP_MAX, CP_MAX, CP_MAX, CP_MAX, CP_MAX};
            PRE_ZIGZAG:  v = '{CP_MIN, CP_MAX, CP_MAX, CP_MIN, CP_MIN, CP_MAX, CP_MAX, CP_MIN};
            PRE_SCURVE:  v = '{0, 0, 24'sh010000, 24'sh030000,
                               24'sh020000, -24'sh030000, 24'sh030000, 0};
            PRE_KINK_POS: v = '{0, 0, 0, 0, CP_MAX, 0, CP_MAX, CP_MAX};
            PRE_KINK_NEG: v = '{0, 0, 0, 0, CP_MAX, 0, CP_MAX, CP_MIN};
            default:     v = '{0, 0, 0, 0, 0, 0, 0, 0};
        endcase
        load_points(v);
    endtask

    // one transfer on the input channel; valid stays up until accepted and
    // the next call either offers the next item or drops valid
    task automatic send_item(input logic [16:0] t, input bit typed,
                             input logic signed [23:0] pt);
        t_curve_sample s;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_param_t <= t;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        if (typed) begin
            s = '{px: pt, py: pt, vx: '0, vy: '0, ax: '0, ay: '0, k: '0};
        end else begin
            predict_sample(t, s);
        end
        pending_samples = {pending_samples, s};
    endtask

    // receiver side backpressure
    initial begin
        int hold;
        bit long_done;
        hold = 0;
        long_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !long_done) begin
                long_done = 1'b1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 15) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_curve_sample e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_samples.size() == 0) begin
                $error("result with no expectation waiting");
                fail_cnt++;
            end else begin
                e = pending_samples.pop_front();
                if (o_point_x !== e.px) begin
                    $error("point_x expected %0d actual %0d", e.px, o_point_x); fail_cnt++;
                end
                if (o_point_y !== e.py) begin
                    $error("point_y expected %0d actual %0d", e.py, o_point_y); fail_cnt++;
                end
                if (o_velocity_x !== e.vx) begin
                    $error("velocity_x expected %0d actual %0d", e.vx, o_velocity_x);
                    fail_cnt++;
                end
                if (o_velocity_y !== e.vy) begin
                    $error("velocity_y expected %0d actual %0d", e.vy, o_velocity_y);
                    fail_cnt++;
                end
                if (o_accel_x !== e.ax) begin
                    $error("accel_x expected %0d actual %0d", e.ax, o_accel_x); fail_cnt++;
                end
                if (o_accel_y !== e.ay) begin
                    $error("accel_y expected %0d actual %0d", e.ay, o_accel_y); fail_cnt++;
                end
                if (o_curvature !== e.k) begin
                    $error("curvature expected %0d actual %0d", e.k, o_curvature);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("cubic_bezier_evaluator verification failed");
            $finish;
        end
    end

    t_dir_row dir_rows [22] = '{
        '{17'd0,      PRE_RESET,    1'b1, 24'sd0},
        '{17'd65536,  PRE_RESET,    1'b1, 24'sd0},
        '{17'd131071, PRE_RESET,    1'b1, 24'sd0},
        '{17'd0,      PRE_ALL_MAX,  1'b1, CP_MAX},
        '{17'd32768,  PRE_ALL_MAX,  1'b1, CP_MAX},
        '{17'd131071, PRE_ALL_MAX,  1'b1, CP_MAX},
        '{17'd0,      PRE_ZIGZAG,   1'b0, 24'sd0},
        '{17'd1,      PRE_ZIGZAG,   1'b0, 24'sd0},
        '{17'd32768,  PRE_ZIGZAG,   1'b0, 24'sd0},
        '{17'd65535,  PRE_ZIGZAG,   1'b0, 24'sd0},
        '{17'd65536,  PRE_ZIGZAG,   1'b0, 24'sd0},
        '{17'd65537,  PRE_ZIGZAG,   1'b0, 24'sd0},
        '{17'd0,      PRE_SCURVE,   1'b0, 24'sd0},
        '{17'd21845,  PRE_SCURVE,   1'b0, 24'sd0},
        '{17'd43690,  PRE_SCURVE,   1'b0, 24'sd0},
        '{17'd98304,  PRE_SCURVE,   1'b0, 24'sd0},
        '{17'd0,      PRE_KINK_POS, 1'b0, 24'sd0},
        '{17'd1,      PRE_KINK_POS, 1'b0, 24'sd0},
        '{17'd16,     PRE_KINK_POS, 1'b0, 24'sd0},
        '{17'd0,      PRE_KINK_NEG, 1'b0, 24'sd0},
        '{17'd1,      PRE_KINK_NEG, 1'b0, 24'sd0},
        '{17'd16,     PRE_KINK_NEG, 1'b0, 24'sd0}
    };

    initial begin
        t_preset cur;
        logic signed [23:0] v [NUM_REGS];
        logic [16:0] t;
        for (int i = 0; i < NUM_REGS; i++) ctrl_pts[i] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        cur = PRE_RESET;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].pre != cur) begin
                cur = dir_rows[r].pre;
                load_preset(cur);
            end
            send_item(dir_rows[r].t, dir_rows[r].typed, dir_rows[r].pt);
        end

        for (int ph = 0; ph < 10; ph++) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                case (ph % 3)
                    0: v[i] = 24'($urandom);
                    1: v[i] = $signed(24'($urandom_range(0, 32'h7FFFF))) - 24'sh40000;
                    default: v[i] = $urandom_range(0, 1) ? CP_MAX : CP_MIN;
                endcase
            end
            load_points(v);
            if (ph == 8) quiet = 1'b1;
            for (int n = 0; n < N_RANDOM / 10; n++) begin
                if (ph == 2 && n == 20) long_hold_req = 1'b1;
                case ($urandom_range(0, 9))
                    0: t = 17'($urandom_range(65537, 131071));
                    1: t = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
                    2: t = 17'($urandom_range(0, 64));
                    default: t = 17'($urandom_range(0, 65536));
                endcase
                send_item(t, 1'b0, 24'sd0);
            end
        end

        wait_idle();
        if (fail_cnt == 0 && pending_samples.size() == 0) begin
            $display("cubic_bezier_evaluator verification clean");
        end else begin
            $display("cubic_bezier_evaluator verification failed");
        end
        $finish;
    end
endmodule

[cubic_bezier_evaluator.f]
rtl/core/cbe_pkg.sv
rtl/core/cubic_bezier_evaluator.sv
tb/sv/tb_cubic_bezier_evaluator.sv
